// ===== rtl/core/cpfm_pkg.sv =====
// Shared types and constants of the capture period and frequency meter.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package cpfm_pkg;

    // Fixed field widths
    localparam int CH_W      = 2;
    localparam int VAL_W     = 32;
    localparam int FREQ_W    = 36;
    localparam int TALLY_W   = 16;
    localparam int ENABLE_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_HZ   = 2'd1;

    localparam logic [VAL_W-1:0] REF_HZ_RESET = 32'd108000000;

    // Event kinds
    localparam logic KIND_OVERFLOW = 1'b0;
    localparam logic KIND_CAPTURE  = 1'b1;

    // Divider geometry: (reference << 4) / period
    localparam int DIVIDEND_W = FREQ_W;
    localparam int DIVISOR_W  = VAL_W;
    localparam int DIV_STEPS  = DIVIDEND_W;

    typedef struct packed {
        logic             en;
        logic             kind;
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] value;
    } cap_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpfm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on cpfm_pkg for widths and the result struct.
`default_nettype none

module cpfm_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [cpfm_pkg::DIVIDEND_W-1:0]  dividend,
    input  wire logic [cpfm_pkg::DIVISOR_W-1:0]   divisor,
    output cpfm_pkg::div_res_t                    res
);

    localparam int DW   = cpfm_pkg::DIVIDEND_W;
    localparam int SW   = cpfm_pkg::DIVISOR_W;
    localparam int CNTW = $clog2(cpfm_pkg::DIV_STEPS + 1);

    logic [DW-1:0]   quo_reg, quo_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [SW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;

    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        ge;

    // Shared subtract and compare unit
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next = {quo_reg[DW-2:0], ge};
        rem_next = ge ? diff[SW-1:0] : trial[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(cpfm_pkg::DIV_STEPS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cpfm_chan_bank.sv =====
// Per-channel capture slots, phase flags and stored periods.
// Depends on cpfm_pkg for the capture request struct.
`default_nettype none

module cpfm_chan_bank #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cpfm_pkg::cap_req_t                req,
    input  wire logic [cpfm_pkg::ENABLE_W-1:0]     channel_enable,
    output logic      [cpfm_pkg::VAL_W-1:0]        period,
    output logic                                   updated
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CB    = COUNTER_BITS;

    logic [CB-1:0] even_reg   [NUM_CHANNELS];
    logic [CB-1:0] odd_reg    [NUM_CHANNELS];
    logic [CB-1:0] period_reg [NUM_CHANNELS];
    logic          phase_reg  [NUM_CHANNELS];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             hit;
    logic [CB-1:0]    cap;
    logic [CB-1:0]    other;
    logic [CB-1:0]    diff;
    logic             gt;

    assign idx      = IDX_W'(req.channel);
    assign in_range = 32'(req.channel) < 32'(NUM_CHANNELS);
    assign hit      = in_range && (req.kind == cpfm_pkg::KIND_CAPTURE)
                      && channel_enable[req.channel];
    assign cap      = req.value[CB-1:0];

    always_comb begin
        if (in_range) begin
            other = phase_reg[idx] ? even_reg[idx] : odd_reg[idx];
        end else begin
            other = '0;
        end
    end

    assign gt   = cap > other;
    assign diff = cap - other;

    assign updated = hit && gt;

    always_comb begin
        if (!in_range) begin
            period = '0;
        end else if (hit && gt) begin
            period = cpfm_pkg::VAL_W'(diff);
        end else begin
            period = cpfm_pkg::VAL_W'(period_reg[idx]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                even_reg[i]   <= '0;
                odd_reg[i]    <= '0;
                period_reg[i] <= '0;
                phase_reg[i]  <= 1'b0;
            end
        end else if (req.en && hit) begin
            // Store into the slot the phase points at, then toggle
            if (phase_reg[idx]) begin
                odd_reg[idx] <= cap;
            end else begin
                even_reg[idx] <= cap;
            end
            phase_reg[idx] <= !phase_reg[idx];
            if (gt) begin
                period_reg[idx] <= diff;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/capture_period_frequency_meter.sv =====
// Top level of the capture period and frequency meter: sequencer, config
// registers and result register. Depends on cpfm_pkg, cpfm_chan_bank, cpfm_div.
//
// Usage:
//   The s_ channel takes one timer event per beat: an overflow (s_kind 0)
//   bumps the 16-bit overflow tally, a capture (s_kind 1) stores s_capture_value
//   into the channel's alternate slot and may set a new period.
//   Every event yields exactly one beat on the m_ channel: channel, period,
//   updated flag, frequency with four fraction bits and the overflow tally.
//   The cfg_ channel writes channel_enable (index 0) or reference_hz
//   (index 1); cfg_ready is always high. Write only while the block is idle.
// Flow:
//   An accepted event first passes the channel update, then the bit-serial
//   divider (one quotient bit per cycle through one shared subtractor); the
//   divider's done flag moves the sequencer to its hold state, from which the
//   result is loaded into the output register once that register is free.
//   s_ready is low while an event is being worked on, so the next event is
//   taken only after the last one's result has been loaded.
// Reset and stalls:
//   Reset clears all capture slots, periods, phases and the tally, sets
//   channel_enable to 0 and reference_hz to 108 MHz. A result held by a low
//   m_ready stays in the output register; the next event is still accepted
//   and its result waits inside until the register frees.
`default_nettype none

module capture_period_frequency_meter #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [cpfm_pkg::CH_W-1:0]          s_channel,
    input  wire logic [cpfm_pkg::VAL_W-1:0]         s_capture_value,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [cpfm_pkg::CH_W-1:0]          m_result_channel,
    output logic      [cpfm_pkg::VAL_W-1:0]         m_period,
    output logic                                    m_period_updated,
    output logic      [cpfm_pkg::FREQ_W-1:0]        m_freq_x16,
    output logic      [cpfm_pkg::TALLY_W-1:0]       m_overflow_tally,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpfm_pkg::VAL_W-1:0]         cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [cpfm_pkg::ENABLE_W-1:0] enable_reg;
    logic [cpfm_pkg::VAL_W-1:0]    ref_hz_reg;
    logic [cpfm_pkg::TALLY_W-1:0]  tally_reg;

    logic                          kind_reg;
    logic [cpfm_pkg::CH_W-1:0]     ch_reg;
    logic [cpfm_pkg::VAL_W-1:0]    cap_reg;
    logic [cpfm_pkg::VAL_W-1:0]    period_reg;
    logic                          upd_reg;

    logic                          out_valid_reg;
    logic [cpfm_pkg::CH_W-1:0]     out_ch_reg;
    logic [cpfm_pkg::VAL_W-1:0]    out_period_reg;
    logic                          out_upd_reg;
    logic [cpfm_pkg::FREQ_W-1:0]   out_freq_reg;
    logic [cpfm_pkg::TALLY_W-1:0]  out_tally_reg;

    cpfm_pkg::cap_req_t            req;
    cpfm_pkg::div_res_t            div_res;
    logic [cpfm_pkg::VAL_W-1:0]    bank_period;
    logic                          bank_updated;
    logic                          s_fire;
    logic                          out_free;
    logic                          load_out;
    logic                          div_start;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_HOLD) && out_free;
    assign div_start = (state_reg == ST_UPD);

    assign req.en      = (state_reg == ST_UPD);
    assign req.kind    = kind_reg;
    assign req.channel = ch_reg;
    assign req.value   = cap_reg;

    cpfm_chan_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_bank (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .channel_enable (enable_reg),
        .period         (bank_period),
        .updated        (bank_updated)
    );

    cpfm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({ref_hz_reg, 4'b0000}),
        .divisor  (bank_period),
        .res      (div_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enable_reg    <= '0;
            ref_hz_reg    <= cpfm_pkg::REF_HZ_RESET;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cpfm_pkg::REG_CHANNEL_ENABLE: enable_reg <= cfg_data[cpfm_pkg::ENABLE_W-1:0];
                    cpfm_pkg::REG_REFERENCE_HZ:   ref_hz_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((state_reg == ST_UPD) && (kind_reg == cpfm_pkg::KIND_OVERFLOW)) begin
                tally_reg <= tally_reg + 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_kind;
            ch_reg   <= s_channel;
            cap_reg  <= s_capture_value;
        end
        if (state_reg == ST_UPD) begin
            period_reg <= bank_period;
            upd_reg    <= bank_updated;
        end
        if (load_out) begin
            out_ch_reg     <= ch_reg;
            out_period_reg <= period_reg;
            out_upd_reg    <= upd_reg;
            out_freq_reg   <= (period_reg == '0) ? '0 : div_res.quotient;
            out_tally_reg  <= tally_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_channel = out_ch_reg;
    assign m_period         = out_period_reg;
    assign m_period_updated = out_upd_reg;
    assign m_freq_x16       = out_freq_reg;
    assign m_overflow_tally = out_tally_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cpfm_checker.sv =====
// Port-level checks of the capture period and frequency meter, bound to the top.
// Depends on cpfm_pkg for port widths.
`default_nettype none

module cpfm_port_checks (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [cpfm_pkg::VAL_W-1:0]         m_period,
    input wire logic                               m_period_updated,
    input wire logic [cpfm_pkg::FREQ_W-1:0]        m_freq_x16
);

    // An accepted event keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an accepted beat");

    // A new result appears as the sequencer returns to idle
    a_result_reopens_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while an event is still in work");

    // No period means no frequency
    a_zero_period_zero_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_period == '0) |-> (m_freq_x16 == '0))
        else $error("non-zero frequency for a zero period");

    // A freshly measured period is never zero
    a_updated_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_period_updated |-> (m_period != '0))
        else $error("updated beat carries a zero period");

    // Hold a stalled result
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_period) && $stable(m_freq_x16))
        else $error("stalled result beat changed");

endmodule

bind capture_period_frequency_meter cpfm_port_checks u_cpfm_port_checks (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_period         (m_period),
    .m_period_updated (m_period_updated),
    .m_freq_x16       (m_freq_x16)
);

`default_nettype wire
